// File: rtl/core/rrt_pkg.sv
// Shared types and constants for the rational rate timer.
// No dependencies; used by rrt_div and rational_rate_timer_with_alarm_top.
package rrt_pkg;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    localparam logic [2:0] REG_STATUS  = 3'd0;
    localparam logic [2:0] REG_ENABLE  = 3'd1;
    localparam logic [2:0] REG_NUMER   = 3'd2;
    localparam logic [2:0] REG_DENOM   = 3'd3;
    localparam logic [2:0] REG_TIME_LO = 3'd4;
    localparam logic [2:0] REG_TIME_HI = 3'd5;
    localparam logic [2:0] REG_ALARM   = 3'd6;

    localparam int RATE_W = 16;
    localparam int WORD_W = 32;
    localparam int TIME_W = 64;

    localparam logic [WORD_W-1:0] LOW_CLEAR_MASK = 32'hFFFF_FFE0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SCALE,
        ST_DIV,
        ST_ADD,
        ST_CMP,
        ST_DONE
    } state_t;

endpackage

// File: rtl/core/rrt_div.sv
// Restoring divider, one quotient bit per cycle.
// Uses rrt_pkg for the divisor width.
module rrt_div #(
    parameter int DIVIDEND_W = 33
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [DIVIDEND_W-1:0]         dividend,
    input  logic [rrt_pkg::RATE_W-1:0]    divisor,
    output logic                          done,
    output logic [DIVIDEND_W-1:0]         quotient
);

    localparam int DW    = rrt_pkg::RATE_W;
    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DW-1:0]         rem_reg, rem_next;
    logic [DW-1:0]         den_reg, den_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  run_reg, run_next;
    logic                  done_reg, done_next;

    logic [DW:0] shifted;
    logic [DW:0] diff;

    assign shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff    = shifted - {1'b0, den_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            den_next = divisor;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = diff[DW-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DW-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIVIDEND_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/core/rational_rate_timer_with_alarm_top.sv
// Rational rate timestamp timer with alarm, status and interrupt enable.
// Reads, writes and zero-rate ticks go from ST_IDLE straight to ST_DONE;
// other ticks pass ST_MUL, ST_SCALE, ST_DIV (rrt_div), ST_ADD and ST_CMP.
// ST_DONE registers each reply when output is free; one request at a time.
// Asynchronous active-low reset clears the timestamp, alarm, rate, status,
// enable and the handshake state. Depends on rrt_pkg and rrt_div.
module rational_rate_timer_with_alarm_top #(
    parameter int TIME_SCALE = 1
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [2:0]  reg_index,
    input  logic [31:0] write_data,
    input  logic [15:0] elapsed_cycles,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_data,
    output logic        alarm_status,
    output logic        interrupt_request
);

    localparam int RW      = rrt_pkg::RATE_W;
    localparam int WW      = rrt_pkg::WORD_W;
    localparam int TW      = rrt_pkg::TIME_W;
    localparam int SCALE_W = $clog2(TIME_SCALE + 1);
    localparam int PROD_W  = 2 * RW + SCALE_W;
    localparam logic [SCALE_W-1:0] SCALE_K = SCALE_W'(TIME_SCALE);

    rrt_pkg::state_t state_reg, state_next;

    logic [TW-1:0] ts_reg, ts_next;
    logic [WW-1:0] alarm_reg, alarm_next;
    logic [RW-1:0] num_reg, num_next;
    logic [RW-1:0] den_reg, den_next;
    logic          pend_reg, pend_next;
    logic          en_reg, en_next;

    logic [RW-1:0]   cyc_reg, cyc_next;
    logic [2*RW-1:0] mul_reg, mul_next;
    logic [WW-1:0]   rd_hold_reg, rd_hold_next;

    logic          out_valid_reg, out_valid_next;
    logic [WW-1:0] read_data_reg, read_data_next;
    logic          status_reg, status_next;
    logic          irq_reg, irq_next;

    logic              div_start;
    logic [PROD_W-1:0] div_dividend;
    logic              div_done;
    logic [PROD_W-1:0] div_quotient;
    logic              accept;
    logic [WW-1:0]     rd_val;
    logic [WW-1:0]     den_wr;

    assign in_ready     = (state_reg == rrt_pkg::ST_IDLE);
    assign accept       = in_valid && in_ready;
    assign div_dividend = PROD_W'(mul_reg) * PROD_W'(SCALE_K);
    assign den_wr       = (write_data == '0) ? WW'(1) : write_data;

    rrt_div #(
        .DIVIDEND_W (PROD_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        unique case (reg_index)
            rrt_pkg::REG_STATUS:  rd_val = WW'(pend_reg);
            rrt_pkg::REG_ENABLE:  rd_val = WW'(en_reg);
            rrt_pkg::REG_NUMER:   rd_val = WW'(num_reg);
            rrt_pkg::REG_DENOM:   rd_val = WW'(den_reg);
            rrt_pkg::REG_TIME_LO: rd_val = ts_reg[WW-1:0];
            rrt_pkg::REG_TIME_HI: rd_val = ts_reg[TW-1:WW];
            rrt_pkg::REG_ALARM:   rd_val = alarm_reg;
            default:              rd_val = '0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        ts_next        = ts_reg;
        alarm_next     = alarm_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        pend_next      = pend_reg;
        en_next        = en_reg;
        cyc_next       = cyc_reg;
        mul_next       = mul_reg;
        rd_hold_next   = rd_hold_reg;
        out_valid_next = out_valid_reg;
        read_data_next = read_data_reg;
        status_next    = status_reg;
        irq_next       = irq_reg;
        div_start      = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            rrt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    rd_hold_next = '0;
                    state_next   = rrt_pkg::ST_DONE;
                    case (kind)
                        rrt_pkg::KIND_TICK:
                        begin
                            cyc_next = elapsed_cycles;
                            if (num_reg != '0 && den_reg != '0)
                                state_next = rrt_pkg::ST_MUL;
                        end
                        rrt_pkg::KIND_READ:
                            rd_hold_next = rd_val;
                        rrt_pkg::KIND_WRITE:
                        begin
                            unique case (reg_index)
                                rrt_pkg::REG_STATUS:
                                    if (write_data[0])
                                        pend_next = 1'b0;
                                rrt_pkg::REG_ENABLE:  en_next = write_data[0];
                                rrt_pkg::REG_NUMER:   num_next = write_data[RW-1:0];
                                rrt_pkg::REG_DENOM:   den_next = den_wr[RW-1:0];
                                rrt_pkg::REG_TIME_LO:
                                    ts_next[WW-1:0] = write_data & rrt_pkg::LOW_CLEAR_MASK;
                                rrt_pkg::REG_TIME_HI:
                                    ts_next[TW-1:WW] = write_data & rrt_pkg::LOW_CLEAR_MASK;
                                rrt_pkg::REG_ALARM:
                                    alarm_next = write_data & rrt_pkg::LOW_CLEAR_MASK;
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                end
            end
            rrt_pkg::ST_MUL:
            begin
                mul_next   = cyc_reg * num_reg;
                state_next = rrt_pkg::ST_SCALE;
            end
            rrt_pkg::ST_SCALE:
            begin
                div_start  = 1'b1;
                state_next = rrt_pkg::ST_DIV;
            end
            rrt_pkg::ST_DIV:
            begin
                if (div_done)
                    state_next = rrt_pkg::ST_ADD;
            end
            rrt_pkg::ST_ADD:
            begin
                ts_next    = ts_reg + TW'(div_quotient);
                state_next = rrt_pkg::ST_CMP;
            end
            rrt_pkg::ST_CMP:
            begin
                if (ts_reg >= TW'(alarm_reg))
                    pend_next = 1'b1;
                state_next = rrt_pkg::ST_DONE;
            end
            rrt_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    read_data_next = rd_hold_reg;
                    status_next    = pend_reg;
                    irq_next       = pend_reg & en_reg;
                    state_next     = rrt_pkg::ST_IDLE;
                end
            end
            default:
                state_next = rrt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rrt_pkg::ST_IDLE;
            ts_reg        <= '0;
            alarm_reg     <= '0;
            num_reg       <= '0;
            den_reg       <= '0;
            pend_reg      <= 1'b0;
            en_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ts_reg        <= ts_next;
            alarm_reg     <= alarm_next;
            num_reg       <= num_next;
            den_reg       <= den_next;
            pend_reg      <= pend_next;
            en_reg        <= en_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cyc_reg       <= cyc_next;
        mul_reg       <= mul_next;
        rd_hold_reg   <= rd_hold_next;
        read_data_reg <= read_data_next;
        status_reg    <= status_next;
        irq_reg       <= irq_next;
    end

    assign out_valid         = out_valid_reg;
    assign read_data         = read_data_reg;
    assign alarm_status      = status_reg;
    assign interrupt_request = irq_reg;

endmodule

// File: verif/rational_rate_timer_with_alarm_top_test.sv
// Self-checking testbench for rational_rate_timer_with_alarm_top: directed and random
// ticks and register requests, with a reply tracker that predicts every reply.
// Depends on rrt_pkg and the timer RTL.
module rational_rate_timer_with_alarm_top_test;

    localparam int TIME_SCALE      = 1;
    localparam int RANDOM_REQUESTS = 1700;
    localparam int LONG_STALL      = 300;
    localparam int DRAIN_CYCLES    = 80;
    localparam int WATCHDOG_CYCLES = 1000000;
    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam logic [2:0] REG_NONE  = 3'd7;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  idx;
        logic [31:0] data;
        logic [15:0] cycles;
    } timer_req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        status;
        logic        irq;
    } timer_reply_t;

    class timer_reply_tracker_t;
        bit [63:0]    timestamp;
        bit [31:0]    alarm;
        bit [15:0]    numer;
        bit [15:0]    denom;
        bit           pending;
        bit           irq_en;
        timer_reply_t replies_due[$];
        int           bad_replies;
        int           reply_count;

        function void take_request(timer_req_t r);
            timer_reply_t due;
            bit [63:0]    product;
            bit [31:0]    v;
            due.read_data = '0;
            case (r.kind)
                rrt_pkg::KIND_TICK:
                begin
                    if (numer != 0 && denom != 0)
                    begin
                        product = 64'(r.cycles) * 64'(numer) * 64'(TIME_SCALE);
                        timestamp += product / 64'(denom);
                        if (timestamp >= {32'd0, alarm})
                            pending = 1'b1;
                    end
                end
                rrt_pkg::KIND_READ:
                begin
                    case (r.idx)
                        rrt_pkg::REG_STATUS:  due.read_data = {31'd0, pending};
                        rrt_pkg::REG_ENABLE:  due.read_data = {31'd0, irq_en};
                        rrt_pkg::REG_NUMER:   due.read_data = {16'd0, numer};
                        rrt_pkg::REG_DENOM:   due.read_data = {16'd0, denom};
                        rrt_pkg::REG_TIME_LO: due.read_data = timestamp[31:0];
                        rrt_pkg::REG_TIME_HI: due.read_data = timestamp[63:32];
                        rrt_pkg::REG_ALARM:   due.read_data = alarm;
                        default:              due.read_data = '0;
                    endcase
                end
                rrt_pkg::KIND_WRITE:
                begin
                    case (r.idx)
                        rrt_pkg::REG_STATUS:  if (r.data[0]) pending = 1'b0;
                        rrt_pkg::REG_ENABLE:  irq_en = r.data[0];
                        rrt_pkg::REG_NUMER:   numer = r.data[15:0];
                        rrt_pkg::REG_DENOM:
                        begin
                            v = (r.data == 0) ? 32'd1 : r.data;
                            denom = v[15:0];
                        end
                        rrt_pkg::REG_TIME_LO:
                            timestamp[31:0] = r.data & rrt_pkg::LOW_CLEAR_MASK;
                        rrt_pkg::REG_TIME_HI:
                            timestamp[63:32] = r.data & rrt_pkg::LOW_CLEAR_MASK;
                        rrt_pkg::REG_ALARM:
                            alarm = r.data & rrt_pkg::LOW_CLEAR_MASK;
                        default: ;
                    endcase
                end
                default: ;
            endcase
            due.status = pending;
            due.irq    = pending & irq_en;
            replies_due.push_back(due);
        endfunction

        function void report_bad(string what, timer_reply_t due, timer_reply_t got);
            bad_replies++;
            if (bad_replies <= 10)
                $display("reply %0d %s: expected rd=%h st=%b irq=%b, got rd=%h st=%b irq=%b",
                         reply_count, what, due.read_data, due.status, due.irq,
                         got.read_data, got.status, got.irq);
        endfunction

        function void check_reply(logic [31:0] rd, logic st, logic irq);
            timer_reply_t got;
            timer_reply_t due;
            got = {rd, st, irq};
            if (replies_due.size() == 0)
            begin
                due = '0;
                report_bad("unexpected", due, got);
            end
            else
            begin
                due = replies_due.pop_front();
                if (got.read_data !== due.read_data || got.status !== due.status ||
                    got.irq !== due.irq)
                    report_bad("mismatch", due, got);
            end
            reply_count++;
        endfunction

        function int outstanding();
            return replies_due.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  kind = '0;
    logic [2:0]  reg_index = '0;
    logic [31:0] write_data = '0;
    logic [15:0] elapsed_cycles = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] read_data;
    logic        alarm_status;
    logic        interrupt_request;

    timer_reply_tracker_t tracker;
    bit sender_gaps_on   = 1'b1;
    bit long_stall_req   = 1'b0;

    rational_rate_timer_with_alarm_top #(
        .TIME_SCALE(TIME_SCALE)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .kind             (kind),
        .reg_index        (reg_index),
        .write_data       (write_data),
        .elapsed_cycles   (elapsed_cycles),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .read_data        (read_data),
        .alarm_status     (alarm_status),
        .interrupt_request(interrupt_request)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 30);
    endfunction

    task automatic offer_request(input timer_req_t r);
        int gap;
        gap = sender_gaps_on ? idle_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        kind           <= r.kind;
        reg_index      <= r.idx;
        write_data     <= r.data;
        elapsed_cycles <= r.cycles;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        tracker.take_request(r);
    endtask

    task automatic offer(input logic [1:0] k, input logic [2:0] idx,
                         input logic [31:0] data, input logic [15:0] cyc);
        timer_req_t r;
        r = {k, idx, data, cyc};
        offer_request(r);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.outstanding() != 0) @(posedge clk);
    endtask

    function automatic timer_req_t random_request();
        timer_req_t r;
        int roll;
        int sel;
        roll = $urandom_range(0, 99);
        sel  = $urandom_range(0, 99);
        r.data   = $urandom;
        r.idx    = 3'($urandom_range(0, 7));
        r.cycles = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
        if (roll < 40)
            r.kind = rrt_pkg::KIND_TICK;
        else if (roll < 68)
            r.kind = rrt_pkg::KIND_READ;
        else if (roll < 96)
        begin
            r.kind = rrt_pkg::KIND_WRITE;
            case (r.idx)
                rrt_pkg::REG_NUMER:
                    if (sel < 70) r.data = {16'($urandom), 16'($urandom_range(0, 40))};
                rrt_pkg::REG_DENOM:
                    if (sel < 10)
                        r.data = '0;
                    else if (sel < 20)
                        r.data = {16'($urandom), 16'd0};
                    else if (sel < 80)
                        r.data = {16'($urandom), 16'($urandom_range(1, 40))};
                rrt_pkg::REG_TIME_LO:
                    if (sel < 50) r.data = $urandom_range(0, 4096);
                rrt_pkg::REG_TIME_HI:
                    if (sel < 70) r.data = '0;
                rrt_pkg::REG_ALARM:
                    if (sel < 70) r.data = tracker.timestamp[31:0] + $urandom_range(0, 20000);
                default: ;
            endcase
        end
        else
            r.kind = KIND_NONE;
        return r;
    endfunction

    // receiver: random back-pressure, plus long hold-offs on request
    initial
    begin : receiver
        int stall_left;
        int cycle_no;
        bit ready_gaps_on;
        stall_left = 0;
        cycle_no = 0;
        ready_gaps_on = 1'b1;
        forever
        begin
            @(posedge clk);
            cycle_no++;
            if (cycle_no % 500 == 0)
                ready_gaps_on = ($urandom_range(0, 3) != 0);
            if (long_stall_req)
            begin
                long_stall_req = 1'b0;
                stall_left = LONG_STALL;
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (ready_gaps_on)
                    stall_left = idle_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_reply(read_data, alarm_status, interrupt_request);
    end

    initial
    begin : watchdog
        #(20 * WATCHDOG_CYCLES);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        int n;
        tracker = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values of every register, including the unmapped index
        for (n = 0; n < 8; n++)
            offer(rrt_pkg::KIND_READ, 3'(n), 32'hFFFF_FFFF, 16'hFFFF);
        // zero rate: tick has no effect
        offer(rrt_pkg::KIND_TICK, REG_NONE, 32'hFFFF_FFFF, 16'hFFFF);
        offer(rrt_pkg::KIND_WRITE, rrt_pkg::REG_NUMER, 32'hFFFF_FFFF, 16'h0000);
        // denominator zero is taken as one
        offer(rrt_pkg::KIND_WRITE, rrt_pkg::REG_DENOM, 32'h0000_0000, 16'hFFFF);
        offer(rrt_pkg::KIND_READ, rrt_pkg::REG_DENOM, 32'h0000_0000, 16'h0000);
        // nonzero write with zero low half leaves denominator zero
        offer(rrt_pkg::KIND_WRITE, rrt_pkg::REG_DENOM, 32'hFFFF_0000, 16'h0000);
        offer(rrt_pkg::KIND_TICK, rrt_pkg::REG_STATUS, 32'h0000_0000, 16'hFFFF);
        offer(rrt_pkg::KIND_WRITE, rrt_pkg::REG_ALARM, 32'hFFFF_FFFF, 16'h0000);
        offer(rrt_pkg::KIND_WRITE, rrt_pkg::REG_DENOM, 32'h0000_0001, 16'h0000);
        offer(rrt_pkg::KIND_WRITE, rrt_pkg::REG_TIME_LO, 32'hFFFF_FFFF, 16'h0000);
        offer(rrt_pkg::KIND_WRITE, rrt_pkg::REG_TIME_HI, 32'hFFFF_FFFF, 16'h0000);
        offer(rrt_pkg::KIND_WRITE, rrt_pkg::REG_ENABLE, 32'hFFFF_FFFF, 16'h0000);
        // timestamp wraps past 2^64
        repeat (32)
            offer(rrt_pkg::KIND_TICK, REG_NONE, 32'h0000_0000, 16'hFFFF);
        offer(rrt_pkg::KIND_WRITE, REG_NONE, 32'hFFFF_FFFF, 16'hFFFF);
        offer(KIND_NONE, REG_NONE, 32'hFFFF_FFFF, 16'hFFFF);
        offer(rrt_pkg::KIND_WRITE, rrt_pkg::REG_STATUS, 32'hFFFF_FFFE, 16'h0000);
        offer(rrt_pkg::KIND_WRITE, rrt_pkg::REG_STATUS, 32'h0000_0001, 16'h0000);
        offer(rrt_pkg::KIND_READ, rrt_pkg::REG_TIME_LO, 32'h0000_0000, 16'h0000);
        offer(rrt_pkg::KIND_TICK, REG_NONE, 32'h0000_0000, 16'h0000);

        for (n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n % 150 == 0)
                sender_gaps_on = ($urandom_range(0, 3) != 0);
            if (n == 300 || n == 1100)
                long_stall_req = 1'b1;
            if (n == 700 || n == 1400)
                wait_drained();
            offer_request(random_request());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.bad_replies == 0 && tracker.outstanding() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/rrt_pkg.sv
rtl/core/rrt_div.sv
rtl/core/rational_rate_timer_with_alarm_top.sv
verif/rational_rate_timer_with_alarm_top_test.sv
